>>> hw/rtl/pfcc_pkg.sv
// pfcc_pkg: shared types and constants for the pcm format channel converter
// item structs, queue entry, operation codes, register indexes and sizes
// no dependencies
package pfcc_pkg;

    localparam int MAX_SPEAKERS = 32;
    localparam int CHAN_W       = 5;
    localparam int CNT_W        = $clog2(MAX_SPEAKERS + 1);
    localparam int SCAN_W       = $clog2(MAX_SPEAKERS);
    localparam int CMP_W        = (CNT_W > CHAN_W) ? CNT_W : CHAN_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK      = 2'd2;

    localparam logic DIR_UNPACK = 1'b0;
    localparam logic DIR_PACK   = 1'b1;

    localparam logic [1:0] FMT_F32 = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S8  = 2'd2;
    localparam logic [1:0] FMT_U8  = 2'd3;

    localparam logic                    DIRECTION_RESET = DIR_UNPACK;
    localparam logic [1:0]              FORMAT_RESET    = FMT_S16;
    localparam logic [MAX_SPEAKERS-1:0] MASK_RESET      = MAX_SPEAKERS'(3);

    localparam logic signed [23:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Q_MIN = 24'sh800000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_UNPACK_F32,
        OP_UNPACK_S16,
        OP_UNPACK_S8,
        OP_UNPACK_U8,
        OP_PACK_F32,
        OP_PACK_S16,
        OP_PACK_S8,
        OP_PACK_U8
    } t_op;

    typedef struct packed {
        logic [31:0]        raw_word;
        logic signed [23:0] mixer_sample;
        logic               first_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         channel_index;
        logic signed [23:0] mixer_sample_out;
        logic [31:0]        raw_word_out;
        logic               last_in_frame;
    } t_out_item;

    typedef struct packed {
        t_op                op;
        logic [31:0]        raw_word;
        logic signed [23:0] mixer_sample;
        logic [CHAN_W-1:0]  chan;
        logic               last;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/pfcc_front.sv
// pfcc_front: accepts items, tracks the frame slot and speaker channel, decodes the operation
// scans the speaker mask over cycles after reset and after each mask write
// depends on pfcc_pkg
module pfcc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  pfcc_pkg::t_in_item                  i_in_item,
    input  logic                                i_direction,
    input  logic [1:0]                          i_sample_format,
    input  logic [pfcc_pkg::MAX_SPEAKERS-1:0]   i_speaker_mask,
    input  logic                                i_mask_wr,
    input  pfcc_pkg::t_q_stat                   i_q_stat,
    output logic                                o_push,
    output pfcc_pkg::t_task                     o_task
);

    logic                          r_sync;
    logic [pfcc_pkg::CNT_W-1:0]    r_scan;
    logic [pfcc_pkg::CNT_W-1:0]    r_scnt;
    logic [pfcc_pkg::CNT_W-1:0]    r_count;
    logic [pfcc_pkg::CHAN_W-1:0]   r_slot;
    logic [pfcc_pkg::CHAN_W-1:0]   r_chan;
    logic [pfcc_pkg::CHAN_W-1:0]   r_first_chan;

    logic                          accept;
    logic                          scan_done;
    logic                          scan_bit;
    logic [pfcc_pkg::CHAN_W-1:0]   slot_eff;
    logic [pfcc_pkg::CHAN_W-1:0]   chan_eff;
    logic [pfcc_pkg::CHAN_W-1:0]   nxt_chan;
    logic                          last;
    pfcc_pkg::t_op                 op;

    assign o_in_stall = r_sync || i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept;

    assign scan_done = (r_scan == pfcc_pkg::CNT_W'(pfcc_pkg::MAX_SPEAKERS));
    assign scan_bit  = !scan_done && i_speaker_mask[r_scan[pfcc_pkg::SCAN_W-1:0]];

    // a new buffer restarts at slot zero, which is the lowest set mask bit
    assign slot_eff = i_in_item.first_of_buffer ? '0 : r_slot;
    assign chan_eff = i_in_item.first_of_buffer ? r_first_chan : r_chan;

    assign last = (r_count == '0) ||
                  (pfcc_pkg::CMP_W'(slot_eff) ==
                   pfcc_pkg::CMP_W'(r_count) - pfcc_pkg::CMP_W'(1));

    // next set mask bit above the current channel
    always_comb begin
        nxt_chan = r_first_chan;
        for (int i = pfcc_pkg::MAX_SPEAKERS - 1; i >= 0; i--) begin
            if (i_speaker_mask[i] && (pfcc_pkg::CHAN_W'(i) > chan_eff)) begin
                nxt_chan = pfcc_pkg::CHAN_W'(i);
            end
        end
    end

    always_comb begin
        unique case ({i_direction, i_sample_format})
            {pfcc_pkg::DIR_UNPACK, pfcc_pkg::FMT_F32}: op = pfcc_pkg::OP_UNPACK_F32;
            {pfcc_pkg::DIR_UNPACK, pfcc_pkg::FMT_S16}: op = pfcc_pkg::OP_UNPACK_S16;
            {pfcc_pkg::DIR_UNPACK, pfcc_pkg::FMT_S8}:  op = pfcc_pkg::OP_UNPACK_S8;
            {pfcc_pkg::DIR_UNPACK, pfcc_pkg::FMT_U8}:  op = pfcc_pkg::OP_UNPACK_U8;
            {pfcc_pkg::DIR_PACK, pfcc_pkg::FMT_F32}:   op = pfcc_pkg::OP_PACK_F32;
            {pfcc_pkg::DIR_PACK, pfcc_pkg::FMT_S16}:   op = pfcc_pkg::OP_PACK_S16;
            {pfcc_pkg::DIR_PACK, pfcc_pkg::FMT_S8}:    op = pfcc_pkg::OP_PACK_S8;
            {pfcc_pkg::DIR_PACK, pfcc_pkg::FMT_U8}:    op = pfcc_pkg::OP_PACK_U8;
            default:                                   op = pfcc_pkg::OP_UNPACK_S16;
        endcase
    end

    always_comb begin
        o_task.op           = op;
        o_task.raw_word     = i_in_item.raw_word;
        o_task.mixer_sample = i_in_item.mixer_sample;
        o_task.chan         = chan_eff;
        o_task.last         = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync       <= 1'b1;
            r_scan       <= '0;
            r_scnt       <= '0;
            r_count      <= '0;
            r_slot       <= '0;
            r_chan       <= '0;
            r_first_chan <= '0;
        end else if (i_mask_wr) begin
            r_sync       <= 1'b1;
            r_scan       <= '0;
            r_scnt       <= '0;
            r_chan       <= '0;
            r_first_chan <= '0;
        end else if (r_sync) begin
            if (scan_done) begin
                r_sync  <= 1'b0;
                r_count <= r_scnt;
                // slot past the end of the new frame wraps to zero
                if (pfcc_pkg::CMP_W'(r_slot) >= pfcc_pkg::CMP_W'(r_scnt)) begin
                    r_slot <= '0;
                    r_chan <= r_first_chan;
                end
            end else begin
                r_scan <= r_scan + pfcc_pkg::CNT_W'(1);
                if (scan_bit) begin
                    r_scnt <= r_scnt + pfcc_pkg::CNT_W'(1);
                    if (pfcc_pkg::CMP_W'(r_scnt) == pfcc_pkg::CMP_W'(r_slot)) begin
                        r_chan <= pfcc_pkg::CHAN_W'(r_scan);
                    end
                    if (r_scnt == '0) begin
                        r_first_chan <= pfcc_pkg::CHAN_W'(r_scan);
                    end
                end
            end
        end else if (accept) begin
            if (last) begin
                r_slot <= '0;
                r_chan <= r_first_chan;
            end else begin
                r_slot <= slot_eff + pfcc_pkg::CHAN_W'(1);
                r_chan <= nxt_chan;
            end
        end
    end

    a_last_wraps_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last && !i_mask_wr) |=> (r_slot == '0))
        else $error("slot did not return to zero after last item of frame");

    a_slot_in_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sync |-> ((r_count == '0 && r_slot == '0) ||
                     (r_count != '0 &&
                      pfcc_pkg::CMP_W'(r_slot) < pfcc_pkg::CMP_W'(r_count))))
        else $error("frame slot outside the speaker frame");

endmodule

>>> hw/rtl/pfcc_queue.sv
// pfcc_queue: short queue of decoded items between the front and the back
// register-based, combinational read of the head entry
// depends on pfcc_pkg
module pfcc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pfcc_pkg::t_task   i_task,
    input  logic              i_pop,
    output pfcc_pkg::t_task   o_task,
    output pfcc_pkg::t_q_stat o_stat
);

    pfcc_pkg::t_task                r_mem [pfcc_pkg::Q_DEPTH];
    logic [pfcc_pkg::Q_PTR_W-1:0]   r_wr;
    logic [pfcc_pkg::Q_PTR_W-1:0]   r_rd;
    logic [pfcc_pkg::Q_CNT_W-1:0]   r_cnt;

    function automatic logic [pfcc_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [pfcc_pkg::Q_PTR_W-1:0] p
    );
        return (p == pfcc_pkg::Q_PTR_W'(pfcc_pkg::Q_DEPTH - 1)) ? '0
                                                               : p + pfcc_pkg::Q_PTR_W'(1);
    endfunction

    assign o_task       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == pfcc_pkg::Q_CNT_W'(pfcc_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + pfcc_pkg::Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - pfcc_pkg::Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

endmodule

>>> hw/rtl/pfcc_back.sv
// pfcc_back: two-stage conversion pipeline with output register
// stage one scales, clamps and finds the float lead bit; stage two packs the float
// depends on pfcc_pkg
module pfcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfcc_pkg::t_task     i_task,
    input  pfcc_pkg::t_q_stat   i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pfcc_pkg::t_out_item o_out_item
);

    typedef struct packed {
        pfcc_pkg::t_op               op;
        logic [pfcc_pkg::CHAN_W-1:0] chan;
        logic                        last;
        logic signed [23:0]          qout;
        logic [31:0]                 wout;
        logic                        fneg;
        logic [23:0]                 fmag;
        logic [4:0]                  fpos;
    } t_stage;

    logic                r_s1_valid;
    t_stage              r_s1;
    logic                r_out_valid;
    pfcc_pkg::t_out_item r_out;

    t_stage              n_s1;
    pfcc_pkg::t_out_item n_out;
    logic                out_ready;
    logic                s1_adv;

    // float unpack
    logic                f_neg;
    logic [7:0]          f_ex;
    logic [22:0]         f_man;
    logic [23:0]         f_sig;
    logic [7:0]          f_sh;
    logic [23:0]         f_mag;
    logic [23:0]         f_q;

    // unsigned 8 unpack: x * 2^22 / 255 = x * 16448 + floor(x * 64 / 255)
    logic [7:0]          u_in;
    logic [13:0]         u_v;
    logic [14:0]         u_corr;
    logic [22:0]         u_tot;
    logic [23:0]         u_q;

    // pack paths
    logic signed [23:0]  x;
    logic signed [23:0]  s16_b;
    logic signed [16:0]  s16_q;
    logic [15:0]         s16_w;
    logic signed [23:0]  s8_b;
    logic signed [8:0]   s8_q;
    logic [7:0]          s8_w;
    logic signed [24:0]  u8_t;
    logic [31:0]         u8_prod;
    logic [9:0]          u8_q10;
    logic [7:0]          u8_w;
    logic [23:0]         pf_mag;
    logic [4:0]          pf_pos;

    // float pack, second stage
    logic [7:0]          pf_exp;
    logic [23:0]         pf_norm;
    logic [31:0]         pf_word;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign s1_adv    = !r_s1_valid || out_ready;
    assign o_pop     = !i_q_stat.empty && s1_adv;

    assign f_neg = i_task.raw_word[31];
    assign f_ex  = i_task.raw_word[30:23];
    assign f_man = i_task.raw_word[22:0];
    assign f_sig = {1'b1, f_man};
    assign f_sh  = 8'd128 - f_ex;
    assign f_mag = (f_sh >= 8'd24) ? '0 : (f_sig >> f_sh[4:0]);

    always_comb begin
        if (f_ex == 8'hFF && f_man != '0) begin
            f_q = '0;
        end else if (f_ex[7]) begin
            f_q = f_neg ? pfcc_pkg::Q_MIN : pfcc_pkg::Q_MAX;
        end else if (f_ex == '0) begin
            f_q = '0;
        end else begin
            f_q = f_neg ? (~f_mag + 24'd1) : f_mag;
        end
    end

    assign u_in   = i_task.raw_word[7:0];
    assign u_v    = {u_in, 6'b0};
    assign u_corr = {1'b0, u_v} + 15'd1 + 15'(u_v[13:8]);
    assign u_tot  = 23'({u_in, 14'b0}) + 23'({u_in, 6'b0}) + 23'(u_corr[14:8]);
    assign u_q    = {1'b0, u_tot} - 24'd2097152;

    assign x = i_task.mixer_sample;

    // truncation toward zero: bias negatives before the shift
    assign s16_b = x[23] ? (x + 24'sd127) : x;
    assign s16_q = $signed(s16_b[23:7]);
    always_comb begin
        if (s16_q > 17'sd32767) begin
            s16_w = 16'h7FFF;
        end else if (s16_q < -17'sd32767) begin
            s16_w = 16'h8001;
        end else begin
            s16_w = s16_q[15:0];
        end
    end

    assign s8_b = x[23] ? (x + 24'sd32767) : x;
    assign s8_q = $signed(s8_b[23:15]);
    always_comb begin
        if (s8_q > 9'sd127) begin
            s8_w = 8'h7F;
        end else if (s8_q < -9'sd127) begin
            s8_w = 8'h81;
        end else begin
            s8_w = s8_q[7:0];
        end
    end

    assign u8_t    = {x[23], x} + 25'sd2097152;
    assign u8_prod = {u8_t[23:0], 8'b0} - {8'b0, u8_t[23:0]};
    assign u8_q10  = u8_prod[31:22];
    always_comb begin
        if (u8_t[24] || u8_t == '0) begin
            u8_w = '0;
        end else if (u8_q10 > 10'd255) begin
            u8_w = 8'hFF;
        end else begin
            u8_w = u8_q10[7:0];
        end
    end

    assign pf_mag = x[23] ? (~x + 24'd1) : x;
    always_comb begin
        pf_pos = '0;
        for (int i = 0; i < 24; i++) begin
            if (pf_mag[i]) begin
                pf_pos = 5'(i);
            end
        end
    end

    always_comb begin
        n_s1      = '0;
        n_s1.op   = i_task.op;
        n_s1.chan = i_task.chan;
        n_s1.last = i_task.last;
        case (i_task.op)
            pfcc_pkg::OP_UNPACK_F32: n_s1.qout = f_q;
            pfcc_pkg::OP_UNPACK_S16: n_s1.qout = {i_task.raw_word[15],
                                                  i_task.raw_word[15:0], 7'b0};
            pfcc_pkg::OP_UNPACK_S8:  n_s1.qout = {i_task.raw_word[7],
                                                  i_task.raw_word[7:0], 15'b0};
            pfcc_pkg::OP_UNPACK_U8:  n_s1.qout = u_q;
            pfcc_pkg::OP_PACK_F32: begin
                n_s1.fneg = x[23];
                n_s1.fmag = pf_mag;
                n_s1.fpos = pf_pos;
            end
            pfcc_pkg::OP_PACK_S16:   n_s1.wout = {16'b0, s16_w};
            pfcc_pkg::OP_PACK_S8:    n_s1.wout = {24'b0, s8_w};
            pfcc_pkg::OP_PACK_U8:    n_s1.wout = {24'b0, u8_w};
            default:                 n_s1.qout = '0;
        endcase
    end

    assign pf_exp  = {3'b0, r_s1.fpos} + 8'd105;
    assign pf_norm = r_s1.fmag << (5'd23 - r_s1.fpos);
    assign pf_word = (r_s1.fmag == '0) ? '0 : {r_s1.fneg, pf_exp, pf_norm[22:0]};

    always_comb begin
        n_out.channel_index    = r_s1.chan;
        n_out.mixer_sample_out = r_s1.qout;
        n_out.raw_word_out     = (r_s1.op == pfcc_pkg::OP_PACK_F32) ? pf_word : r_s1.wout;
        n_out.last_in_frame    = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= o_pop;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (out_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_pop_fills_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped item lost before stage one");

    a_stage_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("stage one changed while blocked");

endmodule

>>> hw/rtl/pcm_format_channel_converter_core.sv
// pcm_format_channel_converter_core: top level of the pcm format channel converter
// holds the configuration registers and joins front, queue and back
// depends on pfcc_pkg, pfcc_front, pfcc_queue, pfcc_back
//
//  channel   dir   handshake                    payload
//  input     in    i_in_valid / o_in_stall      i_in_item  (pfcc_pkg::t_in_item)
//  output    out   o_out_valid / i_out_stall    o_out_item (pfcc_pkg::t_out_item)
//  config    in    i_cfg_we                     i_cfg_index, i_cfg_data
//
// one item per cycle sustained with no output stall or mask scan; an accepted item passes
// the queue entry, stage one and the output register; after reset and every speaker_mask
// write the front scans the mask one bit a cycle, o_in_stall high; other writes act at once
// output stall backs up through stage one into a two-entry queue, o_in_stall rises when full
module pcm_format_channel_converter_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  pfcc_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output pfcc_pkg::t_out_item                o_out_item,
    input  logic                               i_cfg_we,
    input  logic [pfcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfcc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                              r_direction;
    logic [1:0]                        r_format;
    logic [pfcc_pkg::MAX_SPEAKERS-1:0] r_mask;

    logic                              mask_wr;
    logic                              push;
    logic                              pop;
    pfcc_pkg::t_task                   front_task;
    pfcc_pkg::t_task                   head_task;
    pfcc_pkg::t_q_stat                 q_stat;

    assign mask_wr = i_cfg_we && (i_cfg_index == pfcc_pkg::CFG_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= pfcc_pkg::DIRECTION_RESET;
            r_format    <= pfcc_pkg::FORMAT_RESET;
            r_mask      <= pfcc_pkg::MASK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfcc_pkg::CFG_DIRECTION: r_direction <= i_cfg_data[0];
                pfcc_pkg::CFG_FORMAT:    r_format    <= i_cfg_data[1:0];
                pfcc_pkg::CFG_MASK:      r_mask      <= i_cfg_data[pfcc_pkg::MAX_SPEAKERS-1:0];
                default:                 r_mask      <= r_mask;
            endcase
        end
    end

    pfcc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_item       (i_in_item),
        .i_direction     (r_direction),
        .i_sample_format (r_format),
        .i_speaker_mask  (r_mask),
        .i_mask_wr       (mask_wr),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_task          (front_task)
    );

    pfcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .i_pop   (pop),
        .o_task  (head_task),
        .o_stat  (q_stat)
    );

    pfcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_task      (head_task),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
